### design/assert_macros.svh
// assertion macros used by the top-level design file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define KRH_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("implication check failed");

// next-cycle implication, checked out of reset
`define KRH_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

### design/krh_pkg.sv
// types, constants and the base decoder of the k-mer rolling hash
// no dependencies
package krh_pkg;

    localparam int MAX_KMER = 16;
    localparam int HASH_W   = 32;
    localparam int KMER_W   = 5;
    localparam int FMT_W    = 2;
    localparam int SKIP_W   = 2;
    localparam int CHAR_W   = 8;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 5;

    localparam logic [CFG_IDX_W-1:0] REG_KMER_LENGTH = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FILE_FORMAT = 1'd1;

    localparam logic [FMT_W-1:0] FMT_RAW   = 2'd0;
    localparam logic [FMT_W-1:0] FMT_FASTA = 2'd1;
    localparam logic [FMT_W-1:0] FMT_FASTQ = 2'd2;

    localparam logic [KMER_W-1:0] KMER_RESET = 5'd6;
    localparam logic [KMER_W-1:0] KMER_MAX   = 5'(MAX_KMER);
    localparam logic [KMER_W-1:0] KMER_MIN   = 5'd1;

    localparam logic [CHAR_W-1:0] CH_NUL     = 8'h00;
    localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_HEADER  = 8'h3E;  // '>'
    localparam logic [CHAR_W-1:0] CH_AT      = 8'h40;  // '@'
    localparam logic [CHAR_W-1:0] CH_PLUS    = 8'h2B;  // '+'

    localparam logic [SKIP_W-1:0] SKIP_ONE = 2'd1;
    localparam logic [SKIP_W-1:0] SKIP_TWO = 2'd2;

    typedef struct packed {
        logic [HASH_W-1:0] hash;
        logic [KMER_W-1:0] count;
        logic [SKIP_W-1:0] skip;
    } t_state;

    typedef struct packed {
        logic              hash_valid;
        logic [HASH_W-1:0] kmer_hash;
        logic              end_of_sequence;
    } t_result;

    typedef struct packed {
        logic       is_base;
        logic [1:0] code;
    } t_base;

    function automatic t_base decode_base(input logic [CHAR_W-1:0] c);
        t_base b;
        b.is_base = 1'b1;
        unique case (c)
            8'h41, 8'h61:               b.code = 2'd0;
            8'h43, 8'h63:               b.code = 2'd1;
            8'h47, 8'h67:               b.code = 2'd2;
            8'h54, 8'h74, 8'h55, 8'h75: b.code = 2'd3;
            default: begin
                b.is_base = 1'b0;
                b.code    = 2'd0;
            end
        endcase
        return b;
    endfunction

endpackage

### design/krh_update.sv
// next-state and result logic for one sequence byte
// depends on krh_pkg
module krh_update (
    input  krh_pkg::t_state                  i_state,
    input  logic [krh_pkg::CHAR_W-1:0]       i_char,
    input  logic [krh_pkg::KMER_W-1:0]       i_kmer_length,
    input  logic [krh_pkg::FMT_W-1:0]        i_file_format,
    output krh_pkg::t_state                  o_state,
    output krh_pkg::t_result                 o_result
);

    logic [krh_pkg::KMER_W-1:0] k_eff;
    logic [krh_pkg::HASH_W-1:0] mask;
    logic [krh_pkg::HASH_W-1:0] shifted;
    logic [krh_pkg::KMER_W-1:0] count_inc;
    krh_pkg::t_base             base;
    logic                       is_fasta;
    logic                       is_fastq;

    // clamp k into 1..MAX_KMER
    always_comb begin
        if (i_kmer_length < krh_pkg::KMER_MIN) begin
            k_eff = krh_pkg::KMER_MIN;
        end else if (i_kmer_length > krh_pkg::KMER_MAX) begin
            k_eff = krh_pkg::KMER_MAX;
        end else begin
            k_eff = i_kmer_length;
        end
    end

    // mask bit i set when i < 2k
    always_comb begin
        for (int i = 0; i < krh_pkg::HASH_W; i++) begin
            mask[i] = (i < 2 * int'(k_eff));
        end
    end

    assign base      = krh_pkg::decode_base(i_char);
    assign shifted   = ({i_state.hash[krh_pkg::HASH_W-3:0], base.code}) & mask;
    assign count_inc = (i_state.count < k_eff) ? i_state.count + 5'd1 : k_eff;
    assign is_fasta  = (i_file_format == krh_pkg::FMT_FASTA);
    assign is_fastq  = (i_file_format == krh_pkg::FMT_FASTQ);

    always_comb begin
        o_state                  = i_state;
        o_result.hash_valid      = 1'b0;
        o_result.kmer_hash       = '0;
        o_result.end_of_sequence = 1'b0;
        priority if (i_char == krh_pkg::CH_NUL) begin
            o_result.end_of_sequence = 1'b1;
            o_state.hash             = '0;
            o_state.count            = '0;
        end else if (i_state.skip != '0) begin
            if (i_char == krh_pkg::CH_NEWLINE) begin
                o_state.skip = i_state.skip - 2'd1;
            end
        end else if (base.is_base) begin
            o_state.hash  = shifted;
            o_state.count = count_inc;
            if (count_inc >= k_eff) begin
                o_result.hash_valid = 1'b1;
                o_result.kmer_hash  = shifted;
            end
        end else if (i_char == krh_pkg::CH_NEWLINE && (is_fasta || is_fastq)) begin
            o_state = i_state;
        end else if (i_char == krh_pkg::CH_HEADER && is_fasta) begin
            o_state.hash  = '0;
            o_state.count = '0;
            o_state.skip  = krh_pkg::SKIP_ONE;
        end else if (i_char == krh_pkg::CH_AT && is_fastq) begin
            o_state.hash  = '0;
            o_state.count = '0;
            o_state.skip  = krh_pkg::SKIP_ONE;
        end else if (i_char == krh_pkg::CH_PLUS && is_fastq) begin
            o_state.hash  = '0;
            o_state.count = '0;
            o_state.skip  = krh_pkg::SKIP_TWO;
        end else begin
            o_state.hash  = '0;
            o_state.count = '0;
        end
    end

endmodule

### design/kmer_rolling_hash_top.sv
// Rolling 2-bit k-mer hash over a byte stream of sequence text. Each input
// beat carries one byte and yields exactly one result beat, in the next cycle,
// from a single output register; a new byte is taken every cycle while that
// register is free or being emptied, so sustained rate is one byte per cycle
// and only a stall on the output side slows the input. The user must write k
// and the file format via the config port while no beat is in flight; the block does not check.
// depends on krh_pkg, krh_update and assert_macros.svh
`include "assert_macros.svh"

module kmer_rolling_hash_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [krh_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [krh_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [krh_pkg::CHAR_W-1:0]         i_char_byte,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic                               o_hash_valid,
    output logic [krh_pkg::HASH_W-1:0]         o_kmer_hash,
    output logic                               o_end_of_sequence
);

    logic [krh_pkg::KMER_W-1:0] r_kmer_length;
    logic [krh_pkg::FMT_W-1:0]  r_file_format;
    logic [krh_pkg::FMT_W-1:0]  fmt_eff;
    krh_pkg::t_state            r_state;
    krh_pkg::t_state            n_state;
    krh_pkg::t_result           r_result;
    krh_pkg::t_result           n_result;
    logic                       r_out_valid;
    logic                       in_accept;

    assign o_in_stall = r_out_valid && i_out_stall;
    assign in_accept  = i_in_valid && !o_in_stall;

    // unused format code runs as raw
    assign fmt_eff = (r_file_format == krh_pkg::FMT_FASTA ||
                      r_file_format == krh_pkg::FMT_FASTQ) ? r_file_format
                                                          : krh_pkg::FMT_RAW;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kmer_length <= krh_pkg::KMER_RESET;
            r_file_format <= krh_pkg::FMT_RAW;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == krh_pkg::REG_KMER_LENGTH) begin
                r_kmer_length <= i_cfg_data;
            end else if (i_cfg_idx == krh_pkg::REG_FILE_FORMAT) begin
                r_file_format <= i_cfg_data[krh_pkg::FMT_W-1:0];
            end
        end
    end

    krh_update u_update (
        .i_state       (r_state),
        .i_char        (i_char_byte),
        .i_kmer_length (r_kmer_length),
        .i_file_format (fmt_eff),
        .o_state       (n_state),
        .o_result      (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_accept) begin
                r_state     <= n_state;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload, loaded on each accepted byte, while the output slot is free or being emptied
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_result <= n_result;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_hash_valid      = r_result.hash_valid;
    assign o_kmer_hash       = r_result.kmer_hash;
    assign o_end_of_sequence = r_result.end_of_sequence;

    `KRH_ASSERT_IMP(a_hash_zero_unless_valid, i_clk, i_rst_n, o_out_valid && !o_hash_valid, o_kmer_hash == '0)
    `KRH_ASSERT_IMP(a_eos_excludes_hash, i_clk, i_rst_n, o_out_valid && o_end_of_sequence, !o_hash_valid)
    `KRH_ASSERT_IMP(a_count_bounded, i_clk, i_rst_n, 1'b1, r_state.count <= krh_pkg::KMER_MAX)
    `KRH_ASSERT_NXT(a_accept_gives_beat, i_clk, i_rst_n, in_accept, o_out_valid)
    `KRH_ASSERT_NXT(a_nul_clears_count, i_clk, i_rst_n, in_accept && i_char_byte == krh_pkg::CH_NUL, r_state.count == '0 && o_end_of_sequence)

endmodule

### verif/testbench.sv
// self-checking testbench for kmer_rolling_hash_top: directed table, then random text phases
// scoreboard against an in-bench k-mer hash predictor; randomized gaps and stalls on both sides
// depends on krh_pkg and the design files
module testbench;
    import krh_pkg::*;

    localparam int ITEM_TARGET   = 1900;
    localparam int PHASE_BYTES   = 150;
    localparam int QUIET_LIMIT   = 1000;
    localparam int MAX_IDLE      = 13;
    localparam logic [FMT_W-1:0] FMT_UNUSED = 2'd3;
    localparam logic [79:0] BASE_CHARS = "ACGTUacgtu";

    localparam t_result NO_HASH = '{1'b0, 32'd0, 1'b0};
    localparam t_result END_SEQ = '{1'b0, 32'd0, 1'b1};

    typedef enum logic {ROW_BYTE, ROW_CFG} t_row_kind;

    typedef struct packed {
        t_row_kind            kind;
        logic [CFG_IDX_W-1:0] idx;
        logic [CHAR_W-1:0]    data;
        logic                 typed;
        t_result              want;
    } t_stim_row;

    localparam int DIRECTED_ROWS = 34;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx   = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_stall;
    logic [CHAR_W-1:0]     i_char_byte = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic                  o_hash_valid;
    logic [HASH_W-1:0]     o_kmer_hash;
    logic                  o_end_of_sequence;

    kmer_rolling_hash_top dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_char_byte       (i_char_byte),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_hash_valid      (o_hash_valid),
        .o_kmer_hash       (o_kmer_hash),
        .o_end_of_sequence (o_end_of_sequence)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // predictor state and its copy of the registers
    logic [HASH_W-1:0] model_hash;
    int                model_count;
    logic [SKIP_W-1:0] model_skip;
    logic [KMER_W-1:0] model_k;
    logic [FMT_W-1:0]  model_fmt;

    t_result predicted_kmers[$];
    t_result want_res;
    logic    typed_on = 1'b0;
    t_result typed_want = '0;

    bit tx_idle_on = 1'b0;
    bit rx_idle_on = 1'b0;
    int rx_wait = 0;
    int quiet_cycles = 0;
    bit moved;

    int errors = 0;
    int sent_total = 0;
    int results_seen = 0;
    int hashes_seen = 0;
    int ends_seen = 0;
    int settings_used = 0;

    function automatic t_result roll_byte(input logic [CHAR_W-1:0] c);
        t_result           r;
        int                kk;
        int                code;
        logic [HASH_W-1:0] mask;
        logic [FMT_W-1:0]  fmt;
        r   = '0;
        fmt = (model_fmt == FMT_UNUSED) ? FMT_RAW : model_fmt;
        kk  = model_k;
        if (kk < 1) kk = 1;
        if (kk > MAX_KMER) kk = MAX_KMER;
        mask = (2 * kk >= 32) ? 32'hFFFF_FFFF : (32'd1 << (2 * kk)) - 32'd1;
        case (c)
            "A", "a":           code = 0;
            "C", "c":           code = 1;
            "G", "g":           code = 2;
            "T", "t", "U", "u": code = 3;
            default:            code = 4;
        endcase
        if (c == CH_NUL) begin
            r.end_of_sequence = 1'b1;
            model_count = 0;
            model_hash  = '0;
        end else if (model_skip != '0) begin
            if (c == CH_NEWLINE) model_skip = model_skip - 2'd1;
        end else if (code < 4) begin
            model_hash = ((model_hash << 2) | HASH_W'(code)) & mask;
            if (model_count < kk) model_count = model_count + 1;
            else model_count = kk;
            if (model_count >= kk) begin
                r.hash_valid = 1'b1;
                r.kmer_hash  = model_hash;
            end
        end else if (c == CH_NEWLINE && fmt != FMT_RAW) begin
            // newline between sequence lines keeps the k-mer going
        end else begin
            model_count = 0;
            model_hash  = '0;
            if (c == CH_HEADER && fmt == FMT_FASTA) model_skip = SKIP_ONE;
            else if (c == CH_AT && fmt == FMT_FASTQ) model_skip = SKIP_ONE;
            else if (c == CH_PLUS && fmt == FMT_FASTQ) model_skip = SKIP_TWO;
        end
        return r;
    endfunction

    task automatic flag_mismatch(input string what, input longint got, input longint exp);
        errors++;
        $display("mismatch on %s at result %0d: got %0h, expected %0h",
                 what, results_seen, got, exp);
    endtask

    // monitor: input beats feed the predictor, output beats are scored
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            model_hash  = '0;
            model_count = 0;
            model_skip  = '0;
            model_k     = KMER_RESET;
            model_fmt   = FMT_RAW;
        end else begin
            moved = 1'b0;
            if (i_cfg_we) begin
                if (i_cfg_idx == REG_KMER_LENGTH) model_k = i_cfg_data;
                else if (i_cfg_idx == REG_FILE_FORMAT) model_fmt = i_cfg_data[FMT_W-1:0];
            end
            if (i_in_valid && !o_in_stall) begin
                want_res = roll_byte(i_char_byte);
                if (typed_on) want_res = typed_want;
                predicted_kmers.push_back(want_res);
                moved = 1'b1;
            end
            if (o_out_valid && !i_out_stall) begin
                moved = 1'b1;
                results_seen++;
                if (o_hash_valid) hashes_seen++;
                if (o_end_of_sequence) ends_seen++;
                if (predicted_kmers.size() == 0) begin
                    flag_mismatch("unexpected result beat", o_kmer_hash, 0);
                end else begin
                    want_res = predicted_kmers.pop_front();
                    if (o_hash_valid !== want_res.hash_valid)
                        flag_mismatch("hash_valid", o_hash_valid, want_res.hash_valid);
                    if (o_kmer_hash !== want_res.kmer_hash)
                        flag_mismatch("kmer_hash", o_kmer_hash, want_res.kmer_hash);
                    if (o_end_of_sequence !== want_res.end_of_sequence)
                        flag_mismatch("end_of_sequence", o_end_of_sequence,
                                      want_res.end_of_sequence);
                end
                rx_wait = rx_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
            end
            if (moved) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
                if (quiet_cycles >= QUIET_LIMIT) begin
                    $display("watchdog: no beat for %0d cycles", quiet_cycles);
                    $display("*** FAILED ***");
                    $finish;
                end
            end
        end
    end

    // receiver stalls for a drawn number of cycles after every result beat while rx_idle_on is set
    always @(negedge i_clk) begin
        i_out_stall <= (rx_wait > 0);
        if (rx_wait > 0) rx_wait--;
    end

    task automatic send_byte(input logic [CHAR_W-1:0] ch, input logic typed = 1'b0,
                             input t_result want = '0);
        int gap;
        gap = tx_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        typed_on   = typed;
        typed_want = want;
        i_in_valid  <= 1'b1;
        i_char_byte <= ch;
        do @(posedge i_clk); while (o_in_stall);
        sent_total++;
        @(negedge i_clk);
    endtask

    task automatic wait_drained;
        i_in_valid <= 1'b0;
        do @(negedge i_clk); while (predicted_kmers.size() != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        wait_drained();
        repeat (2) @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [CHAR_W-1:0] pick_base();
        return BASE_CHARS[8 * $urandom_range(0, 9) +: 8];
    endfunction

    task automatic send_bases(input int n);
        repeat (n) send_byte(pick_base());
    endtask

    // header or quality text, optionally broken by an end of sequence
    task automatic send_text_line(input int n, input int lo, input int hi);
        repeat (n) begin
            if ($urandom_range(0, 39) == 0) send_byte(CH_NUL);
            else send_byte(CHAR_W'($urandom_range(lo, hi)));
        end
        send_byte(CH_NEWLINE);
    endtask

    t_stim_row directed [DIRECTED_ROWS];

    initial begin
        int phase;
        int phase_end;
        int len;
        logic [CFG_DATA_W-1:0] k_val;
        logic [FMT_W-1:0]      f_val;

        directed = '{
            '{ROW_BYTE, REG_KMER_LENGTH, "A",        1'b1, NO_HASH},
            '{ROW_BYTE, REG_KMER_LENGTH, 8'hFF,      1'b1, NO_HASH},
            '{ROW_CFG,  REG_KMER_LENGTH, 8'd2,       1'b0, NO_HASH},
            '{ROW_BYTE, REG_KMER_LENGTH, "T",        1'b1, NO_HASH},
            '{ROW_BYTE, REG_KMER_LENGTH, "u",        1'b1, '{1'b1, 32'hF, 1'b0}},
            '{ROW_BYTE, REG_KMER_LENGTH, "C",        1'b1, '{1'b1, 32'hD, 1'b0}},
            '{ROW_BYTE, REG_KMER_LENGTH, CH_NEWLINE, 1'b1, NO_HASH},
            '{ROW_BYTE, REG_KMER_LENGTH, "G",        1'b1, NO_HASH},
            '{ROW_BYTE, REG_KMER_LENGTH, "g",        1'b1, '{1'b1, 32'hA, 1'b0}},
            '{ROW_BYTE, REG_KMER_LENGTH, CH_NUL,     1'b1, END_SEQ},
            '{ROW_BYTE, REG_KMER_LENGTH, "a",        1'b1, NO_HASH},
            '{ROW_BYTE, REG_KMER_LENGTH, "c",        1'b1, '{1'b1, 32'h1, 1'b0}},
            '{ROW_CFG,  REG_KMER_LENGTH, 8'd0,       1'b0, NO_HASH},
            '{ROW_BYTE, REG_KMER_LENGTH, "G",        1'b1, '{1'b1, 32'h2, 1'b0}},
            '{ROW_CFG,  REG_FILE_FORMAT, FMT_FASTA,  1'b0, NO_HASH},
            '{ROW_BYTE, REG_KMER_LENGTH, CH_HEADER,  1'b1, NO_HASH},
            '{ROW_BYTE, REG_KMER_LENGTH, "A",        1'b1, NO_HASH},
            '{ROW_BYTE, REG_KMER_LENGTH, CH_NUL,     1'b1, END_SEQ},
            '{ROW_BYTE, REG_KMER_LENGTH, CH_NEWLINE, 1'b1, NO_HASH},
            '{ROW_BYTE, REG_KMER_LENGTH, "T",        1'b1, '{1'b1, 32'h3, 1'b0}},
            '{ROW_CFG,  REG_FILE_FORMAT, FMT_FASTQ,  1'b0, NO_HASH},
            '{ROW_BYTE, REG_KMER_LENGTH, CH_AT,      1'b1, NO_HASH},
            '{ROW_BYTE, REG_KMER_LENGTH, CH_NEWLINE, 1'b1, NO_HASH},
            '{ROW_BYTE, REG_KMER_LENGTH, "G",        1'b1, '{1'b1, 32'h2, 1'b0}},
            '{ROW_BYTE, REG_KMER_LENGTH, CH_PLUS,    1'b1, NO_HASH},
            '{ROW_BYTE, REG_KMER_LENGTH, CH_NEWLINE, 1'b1, NO_HASH},
            '{ROW_BYTE, REG_KMER_LENGTH, "T",        1'b1, NO_HASH},
            '{ROW_BYTE, REG_KMER_LENGTH, CH_NEWLINE, 1'b1, NO_HASH},
            '{ROW_BYTE, REG_KMER_LENGTH, "c",        1'b1, '{1'b1, 32'h1, 1'b0}},
            '{ROW_CFG,  REG_FILE_FORMAT, FMT_UNUSED, 1'b0, NO_HASH},
            '{ROW_CFG,  REG_KMER_LENGTH, 8'd31,      1'b0, NO_HASH},
            '{ROW_BYTE, REG_KMER_LENGTH, CH_NEWLINE, 1'b1, NO_HASH},
            '{ROW_BYTE, REG_KMER_LENGTH, "A",        1'b0, NO_HASH},
            '{ROW_BYTE, REG_KMER_LENGTH, "C",        1'b0, NO_HASH}
        };

        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed[i]) begin
            if (directed[i].kind == ROW_CFG)
                write_reg(directed[i].idx, directed[i].data[CFG_DATA_W-1:0]);
            else
                send_byte(directed[i].data, directed[i].typed, directed[i].want);
        end

        phase = 0;
        while (sent_total < ITEM_TARGET) begin
            case (phase)
                0:       k_val = KMER_MAX;
                1:       k_val = 5'd31;
                2:       k_val = KMER_MIN;
                default: begin
                    case ($urandom_range(0, 5))
                        0:       k_val = 5'd0;
                        1:       k_val = 5'd31;
                        2:       k_val = CFG_DATA_W'($urandom_range(17, 30));
                        default: k_val = CFG_DATA_W'($urandom_range(1, 16));
                    endcase
                end
            endcase
            f_val = (phase < 8) ? FMT_W'(phase % 4) : FMT_W'($urandom_range(0, 3));
            write_reg(REG_KMER_LENGTH, k_val);
            write_reg(REG_FILE_FORMAT, CFG_DATA_W'(f_val));
            settings_used++;

            phase_end = sent_total + PHASE_BYTES;
            while (sent_total < phase_end) begin
                tx_idle_on = ($urandom_range(0, 3) != 0);
                rx_idle_on = ($urandom_range(0, 3) != 0);
                if ($urandom_range(0, 29) == 0) wait_drained();
                if ($urandom_range(0, 9) == 0) begin
                    // noise and broken records
                    repeat ($urandom_range(1, 4)) send_byte(CHAR_W'($urandom_range(0, 255)));
                end else if (f_val == FMT_FASTA) begin
                    send_byte(CH_HEADER);
                    send_text_line($urandom_range(0, 10), 32, 126);
                    repeat ($urandom_range(1, 3)) begin
                        send_bases($urandom_range(1, 30));
                        send_byte(CH_NEWLINE);
                    end
                    if ($urandom_range(0, 3) == 0) send_byte(CH_NUL);
                end else if (f_val == FMT_FASTQ) begin
                    len = $urandom_range(1, 30);
                    send_byte(CH_AT);
                    send_text_line($urandom_range(0, 10), 32, 126);
                    send_bases(len);
                    send_byte(CH_NEWLINE);
                    send_byte(CH_PLUS);
                    send_text_line($urandom_range(0, 3), 32, 126);
                    send_text_line(len, 33, 74);
                    if ($urandom_range(0, 3) == 0) send_byte(CH_NUL);
                end else begin
                    send_bases($urandom_range(1, 40));
                    case ($urandom_range(0, 2))
                        0:       send_byte(CH_NEWLINE);
                        1:       send_byte(CH_NUL);
                        default: send_byte(CHAR_W'($urandom_range(0, 255)));
                    endcase
                end
            end
            phase++;
        end

        wait_drained();
        repeat (4) @(negedge i_clk);
        if (predicted_kmers.size() != 0)
            flag_mismatch("results never delivered", 0, predicted_kmers.size());

        $display("sent %0d bytes over %0d random settings plus the directed table",
                 sent_total, settings_used);
        $display("scored %0d results: %0d k-mer hashes, %0d sequence ends, %0d mismatches",
                 results_seen, hashes_seen, ends_seen, errors);
        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
